// ===== rtl/stpid_pkg.sv =====
// ----------------------------------------------------------------------------
// Steering torque PID package
// Shared widths, constants, register codes and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package stpid_pkg;

    localparam int ANGLE_W    = 20;
    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 19;
    localparam int RAW_W      = ANGLE_W + 2;   // target - measured + offset
    localparam int DIFF_W     = ANGLE_W + 1;   // error difference
    localparam int PROD_W     = 37;            // gain product
    localparam int ACC_W      = PROD_W + 2;    // sum of three products
    localparam int FRAC_W     = 8;
    localparam int TQ_W       = ACC_W - FRAC_W;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic signed [ANGLE_W-1:0] ANGLE_OFFSET          = 20'sd0;
    localparam logic        [ANGLE_W-1:0] SMALL_ERROR_THRESHOLD = 20'd256;

    localparam logic signed [RAW_W-1:0] ERR_MAX = 22'sd524287;
    localparam logic signed [RAW_W-1:0] ERR_MIN = -22'sd524288;

    // Lazy mode: 10*|e| < 768 reduces to |e| < ceil(768/10)
    localparam int                 LAZY_ERR_X10   = 768;
    localparam logic [ANGLE_W-1:0] LAZY_ERR_LIMIT = ANGLE_W'((LAZY_ERR_X10 + 9) / 10);
    localparam logic [ANGLE_W-1:0] LAZY_TARGET    = 20'd768;
    localparam logic [SPEED_W-1:0] LAZY_SPEED     = 16'd2560;
    localparam logic signed [TQ_W-1:0] LAZY_DRIVE = 31'sd2560;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = 39'sd128;

    typedef enum logic [2:0] {
        REG_GAIN_PROP          = 3'd0,
        REG_GAIN_INTEGRAL      = 3'd1,
        REG_GAIN_DERIV         = 3'd2,
        REG_FINE_GAIN_PROP     = 3'd3,
        REG_FINE_GAIN_INTEGRAL = 3'd4,
        REG_FINE_GAIN_DERIV    = 3'd5,
        REG_INTEGRAL_LIMIT     = 3'd6,
        REG_TORQUE_LIMIT       = 3'd7
    } stpid_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_prop;
        logic [GAIN_W-1:0]  gain_integral;
        logic [GAIN_W-1:0]  gain_deriv;
        logic [GAIN_W-1:0]  fine_gain_prop;
        logic [GAIN_W-1:0]  fine_gain_integral;
        logic [GAIN_W-1:0]  fine_gain_deriv;
        logic [LIMIT_W-1:0] integral_limit;
        logic [LIMIT_W-1:0] torque_limit;
    } stpid_cfg_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] err;
        logic signed [ANGLE_W-1:0] integ;
        logic signed [DIFF_W-1:0]  diff;
        logic [GAIN_W-1:0]         kp;
        logic [GAIN_W-1:0]         ki;
        logic [GAIN_W-1:0]         kd;
        logic                      lazy;
        logic                      err_pos;
    } stpid_ops_t;

endpackage

`default_nettype wire

// ===== rtl/stpid_regs.sv =====
// ----------------------------------------------------------------------------
// Steering torque PID register file
// APB-style gain and limit registers.
// ----------------------------------------------------------------------------
`default_nettype none

module stpid_regs
    import stpid_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output stpid_cfg_t                 cfg
);

    stpid_cfg_t cfg_reg;
    stpid_cfg_t cfg_next;
    stpid_reg_t idx;
    logic       wr_en;

    assign idx    = stpid_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GAIN_PROP:          cfg_next.gain_prop          = pwdata[GAIN_W-1:0];
                REG_GAIN_INTEGRAL:      cfg_next.gain_integral      = pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV:         cfg_next.gain_deriv         = pwdata[GAIN_W-1:0];
                REG_FINE_GAIN_PROP:     cfg_next.fine_gain_prop     = pwdata[GAIN_W-1:0];
                REG_FINE_GAIN_INTEGRAL: cfg_next.fine_gain_integral = pwdata[GAIN_W-1:0];
                REG_FINE_GAIN_DERIV:    cfg_next.fine_gain_deriv    = pwdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT:     cfg_next.integral_limit     = pwdata[LIMIT_W-1:0];
                REG_TORQUE_LIMIT:       cfg_next.torque_limit       = pwdata[LIMIT_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    always_comb
    begin
        case (idx)
            REG_GAIN_PROP:          prdata = APB_DATA_W'(cfg_reg.gain_prop);
            REG_GAIN_INTEGRAL:      prdata = APB_DATA_W'(cfg_reg.gain_integral);
            REG_GAIN_DERIV:         prdata = APB_DATA_W'(cfg_reg.gain_deriv);
            REG_FINE_GAIN_PROP:     prdata = APB_DATA_W'(cfg_reg.fine_gain_prop);
            REG_FINE_GAIN_INTEGRAL: prdata = APB_DATA_W'(cfg_reg.fine_gain_integral);
            REG_FINE_GAIN_DERIV:    prdata = APB_DATA_W'(cfg_reg.fine_gain_deriv);
            REG_INTEGRAL_LIMIT:     prdata = APB_DATA_W'(cfg_reg.integral_limit);
            REG_TORQUE_LIMIT:       prdata = APB_DATA_W'(cfg_reg.torque_limit);
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/stpid_front.sv =====
// ----------------------------------------------------------------------------
// Steering torque PID front end
// Input register, error/integral/derivative state and operand register.
// ----------------------------------------------------------------------------
`default_nettype none

module stpid_front
    import stpid_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_cmd,
    input  wire logic [ANGLE_W-1:0]   in_meas,
    input  wire logic [ANGLE_W-1:0]   in_tgt,
    input  wire logic [SPEED_W-1:0]   in_spd,
    input  stpid_cfg_t                cfg,
    output logic                      op_valid,
    input  wire logic                 op_ready,
    output stpid_ops_t                ops
);

    // input stage
    logic                       v1_reg;
    logic                       cmd1_reg;
    logic signed [ANGLE_W-1:0]  meas1_reg;
    logic signed [ANGLE_W-1:0]  tgt1_reg;
    logic        [SPEED_W-1:0]  spd1_reg;

    // operand stage
    logic                       v2_reg;
    stpid_ops_t                 ops_reg;
    stpid_ops_t                 ops_next;

    // controller state
    logic signed [ANGLE_W-1:0]  integ_reg;
    logic signed [ANGLE_W-1:0]  integ_next;
    logic signed [ANGLE_W-1:0]  prev_err_reg;
    logic                       prev_valid_reg;

    logic                       ld1;
    logic                       ld2;
    logic                       take1;

    logic signed [RAW_W-1:0]    err_raw;
    logic signed [ANGLE_W-1:0]  err;
    logic signed [DIFF_W-1:0]   integ_sum;
    logic signed [DIFF_W-1:0]   lim_pos;
    logic signed [DIFF_W-1:0]   lim_neg;
    logic signed [ANGLE_W-1:0]  integ_clamp;
    logic        [ANGLE_W-1:0]  err_abs;
    logic        [ANGLE_W-1:0]  tgt_abs;
    logic                       fine;
    logic                       lazy;

    assign ld2      = !v2_reg || op_ready;
    assign take1    = v1_reg && ld2;
    assign ld1      = !v1_reg || take1;
    assign in_ready = ld1;
    assign op_valid = v2_reg;
    assign ops      = ops_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ld1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            cmd1_reg  <= in_cmd;
            meas1_reg <= $signed(in_meas);
            tgt1_reg  <= $signed(in_tgt);
            spd1_reg  <= in_spd;
        end
    end

    always_comb
    begin
        err_raw = RAW_W'(tgt1_reg) - RAW_W'(meas1_reg) + RAW_W'(ANGLE_OFFSET);
        if (err_raw > ERR_MAX)
            err = ERR_MAX[ANGLE_W-1:0];
        else if (err_raw < ERR_MIN)
            err = ERR_MIN[ANGLE_W-1:0];
        else
            err = err_raw[ANGLE_W-1:0];

        integ_sum = DIFF_W'(integ_reg) + DIFF_W'(err);
        lim_pos   = $signed({2'b00, cfg.integral_limit});
        lim_neg   = -lim_pos;
        if (integ_sum > lim_pos)
            integ_clamp = lim_pos[ANGLE_W-1:0];
        else if (integ_sum < lim_neg)
            integ_clamp = lim_neg[ANGLE_W-1:0];
        else
            integ_clamp = integ_sum[ANGLE_W-1:0];

        err_abs = err[ANGLE_W-1] ? (~err + 1'b1) : err;
        tgt_abs = tgt1_reg[ANGLE_W-1] ? (~tgt1_reg + 1'b1) : tgt1_reg;
        fine    = err_abs < SMALL_ERROR_THRESHOLD;
        lazy    = (err_abs < LAZY_ERR_LIMIT) && (tgt_abs < LAZY_TARGET)
                  && (spd1_reg < LAZY_SPEED);

        ops_next.err     = err;
        ops_next.integ   = integ_clamp;
        ops_next.diff    = prev_valid_reg ? (DIFF_W'(err) - DIFF_W'(prev_err_reg)) : '0;
        ops_next.kp      = fine ? cfg.fine_gain_prop     : cfg.gain_prop;
        ops_next.ki      = fine ? cfg.fine_gain_integral : cfg.gain_integral;
        ops_next.kd      = fine ? cfg.fine_gain_deriv    : cfg.gain_deriv;
        ops_next.lazy    = lazy;
        ops_next.err_pos = !err[ANGLE_W-1] && (err != '0);

        // clear and lazy steps both drop the integral
        if (cmd1_reg || lazy)
            integ_next = '0;
        else
            integ_next = integ_clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg      <= '0;
            prev_err_reg   <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (take1)
        begin
            integ_reg <= integ_next;
            if (!cmd1_reg)
            begin
                prev_err_reg   <= err;
                prev_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ld2)
            v2_reg <= v1_reg && !cmd1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
            ops_reg <= ops_next;
    end

endmodule

`default_nettype wire

// ===== rtl/stpid_mac.sv =====
// ----------------------------------------------------------------------------
// Steering torque PID multiply and output stage
// Gain products, rounding sum, lazy drive select, torque clip, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stpid_mac
    import stpid_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                op_valid,
    output logic                     op_ready,
    input  stpid_ops_t               ops,
    input  stpid_cfg_t               cfg,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [ANGLE_W-1:0]       out_torque,
    output logic                     out_clipped,
    output logic                     out_lazy
);

    logic                       v3_reg;
    logic signed [PROD_W-1:0]   pe_reg;
    logic signed [PROD_W-1:0]   pi_reg;
    logic signed [PROD_W-1:0]   pd_reg;
    logic                       lazy3_reg;
    logic                       pos3_reg;

    logic                       vo_reg;
    logic [ANGLE_W-1:0]         torque_reg;
    logic                       clip_reg;
    logic                       lazyo_reg;

    logic                       out_free;
    logic                       ld3;

    logic signed [ANGLE_W-1:0]  op_err;
    logic signed [ANGLE_W-1:0]  op_integ;
    logic signed [DIFF_W-1:0]   op_diff;
    logic signed [GAIN_W:0]     kp_s;
    logic signed [GAIN_W:0]     ki_s;
    logic signed [GAIN_W:0]     kd_s;

    logic signed [ACC_W-1:0]    acc;
    logic signed [TQ_W-1:0]     tq_pid;
    logic signed [TQ_W-1:0]     tq;
    logic signed [TQ_W-1:0]     tlim_pos;
    logic signed [TQ_W-1:0]     tlim_neg;
    logic signed [TQ_W-1:0]     tq_clip;
    logic                       clipped;

    assign out_free    = !vo_reg || out_ready;
    assign ld3         = !v3_reg || out_free;
    assign op_ready    = ld3;
    assign out_valid   = vo_reg;
    assign out_torque  = torque_reg;
    assign out_clipped = clip_reg;
    assign out_lazy    = lazyo_reg;

    assign op_err   = ops.err;
    assign op_integ = ops.integ;
    assign op_diff  = ops.diff;
    assign kp_s     = $signed({1'b0, ops.kp});
    assign ki_s     = $signed({1'b0, ops.ki});
    assign kd_s     = $signed({1'b0, ops.kd});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (ld3)
            v3_reg <= op_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            pe_reg    <= op_err * kp_s;
            pi_reg    <= op_integ * ki_s;
            pd_reg    <= op_diff * kd_s;
            lazy3_reg <= ops.lazy;
            pos3_reg  <= ops.err_pos;
        end
    end

    always_comb
    begin
        // floor of (sum + half) over 2^8 rounds half toward plus infinity
        acc    = ACC_W'(pe_reg) + ACC_W'(pi_reg) + ACC_W'(pd_reg) + ROUND_HALF;
        tq_pid = acc[ACC_W-1:FRAC_W];

        if (lazy3_reg)
            tq = pos3_reg ? LAZY_DRIVE : -LAZY_DRIVE;
        else
            tq = tq_pid;

        tlim_pos = $signed({{(TQ_W - LIMIT_W){1'b0}}, cfg.torque_limit});
        tlim_neg = -tlim_pos;
        if (tq > tlim_pos)
        begin
            tq_clip = tlim_pos;
            clipped = 1'b1;
        end
        else if (tq < tlim_neg)
        begin
            tq_clip = tlim_neg;
            clipped = 1'b1;
        end
        else
        begin
            tq_clip = tq;
            clipped = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (out_free)
            vo_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            torque_reg <= tq_clip[ANGLE_W-1:0];
            clip_reg   <= clipped;
            lazyo_reg  <= lazy3_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/steering_torque_pid.sv =====
// ----------------------------------------------------------------------------
// Steering torque PID controller
// Fixed-point gain-scheduled PID with integral clamp, lazy drive and clip.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns the torque for a control
// step through the input, operand, product and output registers; a clear
// request updates the integral and returns nothing. Throughput is one
// request per cycle whenever the result side keeps up: the error, integral
// and derivative state closes its loop inside the single front stage, so a
// step sees the state left by the step just before it. The remaining stages
// are the gain multipliers and the round/clip/output register. A result
// waiting on m_tready holds in the output register while earlier stages
// keep filling, so s_tready drops only when every stage holds an item. Gains
// and limits sit in eight 32-bit APB registers at byte addresses 0x00 to
// 0x1C and should be written while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_torque_pid
    import stpid_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    // request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [19:0] measured_angle, [39:20] target_angle, [55:40] vehicle_speed
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [0] cmd
    input  wire logic [0:0]            s_tuser,

    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [19:0] torque, [20] torque_clipped, [21] lazy_mode, [23:22] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    stpid_cfg_t          cfg;
    stpid_ops_t          ops;
    logic                op_valid;
    logic                op_ready;
    logic [ANGLE_W-1:0]  torque;
    logic                torque_clipped;
    logic                lazy_mode;

    // gain and limit registers
    stpid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // error, integral and derivative; gain set and lazy decision
    stpid_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser[0]),
        .in_meas  (s_tdata[ANGLE_W-1:0]),
        .in_tgt   (s_tdata[2*ANGLE_W-1:ANGLE_W]),
        .in_spd   (s_tdata[2*ANGLE_W+SPEED_W-1:2*ANGLE_W]),
        .cfg      (cfg),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .ops      (ops)
    );

    // products, rounding, lazy drive, clip and result register
    stpid_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op_ready    (op_ready),
        .ops         (ops),
        .cfg         (cfg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_torque  (torque),
        .out_clipped (torque_clipped),
        .out_lazy    (lazy_mode)
    );

    assign m_tdata = {2'b00, lazy_mode, torque_clipped, torque};

endmodule

`default_nettype wire

// ===== rtl/stpid_checker.sv =====
// ----------------------------------------------------------------------------
// Steering torque PID port checker
// Port-level assertions on results and flow control, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stpid_checker
    import stpid_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    logic signed [ANGLE_W-1:0] torque;
    logic                      clipped;
    logic                      lazy;

    assign torque  = $signed(m_tdata[ANGLE_W-1:0]);
    assign clipped = m_tdata[ANGLE_W];
    assign lazy    = m_tdata[ANGLE_W+1];

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // requests back up only behind a stalled result
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request side stalled without output backpressure");

    // unclipped lazy drive is exactly plus or minus ten units
    a_lazy_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && lazy && !clipped |-> torque == 20'sd2560 || torque == -20'sd2560)
        else $error("lazy drive magnitude wrong");

    // a clipped lazy drive lies strictly inside the drive level
    a_lazy_clip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && lazy && clipped |-> torque < 20'sd2560 && torque > -20'sd2560)
        else $error("clipped lazy drive out of range");

endmodule

bind steering_torque_pid stpid_checker u_stpid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
